[design/qmfg_pkg.sv]
// ----------------------------------------------------------------------------
// qmfg_pkg: shared definitions for the quartic mean-field gradient unit
// Widths, fixed-point constants, the sequencer states and the multiplier
// request/response bundles.
// ----------------------------------------------------------------------------
package qmfg_pkg;

	localparam int MAX_SITES = 64;
	localparam int SITE_W    = $clog2(MAX_SITES);
	localparam int CNT_W     = $clog2(MAX_SITES + 1);
	localparam int CFG_W     = 7;

	localparam int POS_W     = 32;
	localparam int GRAD_W    = 48;
	localparam int IDX_W     = 6;
	localparam int TDATA_W   = 56;

	localparam int FRAC_Q    = 28;
	localparam int FRAC_R    = 48;
	localparam int RECIP_W   = FRAC_R + 1;
	localparam int DIVC_W    = $clog2(RECIP_W);

	// squares and cubes of a Q4.28 value, and the running sums over the vector
	localparam int X2_W      = 36;
	localparam int X3_W      = 39;
	localparam int S1_W      = POS_W + SITE_W + 1;
	localparam int S2_W      = X2_W + SITE_W + 1;
	localparam int S3_W      = X3_W + SITE_W + 1;

	// shared multiplier: signed operands, magnitude processed 16 bits a cycle
	localparam int MUL_W     = 44 + SITE_W;
	localparam int MAG_W     = MUL_W - 1;
	localparam int DIG_N     = (MAG_W + 15) / 16;
	localparam int DIG_W     = $clog2(DIG_N);
	localparam int ACC_W     = 2 * MAG_W;

	localparam logic [ACC_W:0] HALF_Q = (ACC_W + 1)'(1) << (FRAC_Q - 1);
	localparam logic [ACC_W:0] HALF_R = (ACC_W + 1)'(1) << (FRAC_R - 1);

	localparam logic signed [MUL_W-1:0] GRAD_HI = MUL_W'((64'sd1 <<< (GRAD_W - 1)) - 64'sd1);
	localparam logic signed [MUL_W-1:0] GRAD_LO = MUL_W'(-(64'sd1 <<< (GRAD_W - 1)));

	localparam logic [CFG_W-1:0] SITES_RESET = CFG_W'(64);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_XX,
		ST_MUL_X2X,
		ST_LOAD_ACC,
		ST_DIV,
		ST_FETCH,
		ST_CAPTURE,
		ST_COUPLE,
		ST_MUL_S1,
		ST_MUL_S2,
		ST_MUL_CR,
		ST_SUM,
		ST_PUSH
	} qmfg_state_t;

	typedef struct packed {
		logic                    start;
		logic                    shift48;
		logic signed [MUL_W-1:0] op_a;
		logic signed [MUL_W-1:0] op_b;
	} qmfg_mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [MUL_W-1:0] value;
	} qmfg_mul_rsp_t;

endpackage

[design/quartic_meanfield_gradient_unit.sv]
// ----------------------------------------------------------------------------
// quartic_meanfield_gradient_unit: mean-field gradient over a position vector
// Loads N positions, then streams one saturated Q20.28 gradient per site.
// ----------------------------------------------------------------------------
// Positions arrive one per transaction as signed Q4.28 and go into a 64-entry
// store while the sums of q, q^2 and q^3 build up. A loading transaction makes
// two passes through the shared multiplier, plus accept and accumulate. After
// the N-th position a bit-serial divider forms the Q.48 reciprocal of N-1,
// then each site makes five products on the same multiplier (q^2, q^3,
// q^2*S1, q*S2 and the coupling times the reciprocal) and steps for store
// read, capture, coupling, sum and output. The multiplier works through its
// second operand 16 bits a cycle. The input is not ready while an item is
// being worked on; a finished gradient waits in the output register so the
// next position may be taken meanwhile. Writing site_count discards any
// part-loaded vector; values below 2 act as 2 and values above 64 as 64.
// Gradients outside Q20.28 are clipped and flagged on tuser.
// ----------------------------------------------------------------------------
module quartic_meanfield_gradient_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [qmfg_pkg::CFG_W-1:0]       cfg_wdata,   // site_count
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [qmfg_pkg::POS_W-1:0]       s_tdata,     // [31:0] position
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [qmfg_pkg::TDATA_W-1:0]     m_tdata,     // [47:0] gradient, [53:48] site_index
	output logic                             m_tlast,     // last_site
	output logic                             m_tuser      // [0] saturated
);

	qmfg_pkg::qmfg_state_t state_q, state_d;

	// configuration and vector bookkeeping
	logic [qmfg_pkg::CFG_W-1:0]          cfg_q;
	logic [qmfg_pkg::CNT_W-1:0]          n_eff;
	logic [qmfg_pkg::SITE_W-1:0]         nm1;
	logic [qmfg_pkg::CNT_W-1:0]          load_cnt_q;
	logic [qmfg_pkg::SITE_W-1:0]         site_q;
	logic                                emit_q;
	logic                                issued_q;
	logic                                load_done;
	logic                                last_site;

	// running sums
	logic signed [qmfg_pkg::S1_W-1:0]    sum1_q;
	logic signed [qmfg_pkg::S2_W-1:0]    sum2_q;
	logic signed [qmfg_pkg::S3_W-1:0]    sum3_q;

	// per-site working values
	logic [qmfg_pkg::POS_W-1:0]          pos_store [qmfg_pkg::MAX_SITES];
	logic [qmfg_pkg::POS_W-1:0]          rd_q;
	logic signed [qmfg_pkg::POS_W-1:0]   x_q;
	logic signed [qmfg_pkg::X2_W-1:0]    x2_q;
	logic signed [qmfg_pkg::X3_W-1:0]    x3_q;
	logic signed [qmfg_pkg::MUL_W-1:0]   c_q;
	logic signed [qmfg_pkg::MUL_W-1:0]   term_q;
	logic signed [qmfg_pkg::MUL_W-1:0]   g_q;
	logic signed [qmfg_pkg::MUL_W-1:0]   nx3;
	logic signed [qmfg_pkg::MUL_W-1:0]   triple;

	// reciprocal divider
	logic [qmfg_pkg::RECIP_W-1:0]        recip_q;
	logic [qmfg_pkg::SITE_W-1:0]         rem_q;
	logic [qmfg_pkg::DIVC_W-1:0]         div_cnt_q;
	logic [qmfg_pkg::RECIP_W-1:0]        dividend;
	logic [qmfg_pkg::SITE_W:0]           div_t;
	logic                                div_ge;
	logic [qmfg_pkg::SITE_W-1:0]         div_rem_n;

	// output register
	logic                                m_valid_q;
	logic [qmfg_pkg::TDATA_W-1:0]        m_data_q;
	logic                                m_last_q;
	logic                                m_sat_q;
	logic                                out_free;
	logic                                sat_hi;
	logic                                sat_lo;
	logic [qmfg_pkg::GRAD_W-1:0]         grad_clip;

	qmfg_pkg::qmfg_mul_req_t             mul_req;
	qmfg_pkg::qmfg_mul_rsp_t             mul_rsp;
	logic                                mul_state;

	// clamp the site count into the supported range
	always_comb begin
		priority if (cfg_q < qmfg_pkg::CFG_W'(2))
			n_eff = qmfg_pkg::CNT_W'(2);
		else if (int'(cfg_q) > qmfg_pkg::MAX_SITES)
			n_eff = qmfg_pkg::CNT_W'(qmfg_pkg::MAX_SITES);
		else
			n_eff = qmfg_pkg::CNT_W'(cfg_q);
	end

	assign nm1       = qmfg_pkg::SITE_W'(n_eff - 1'b1);
	assign load_done = qmfg_pkg::CNT_W'(load_cnt_q + 1'b1) == n_eff;
	assign last_site = site_q == nm1;
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = state_q == qmfg_pkg::ST_IDLE;

	// restoring division of 2^48 + (N-1)/2 by N-1, one quotient bit a cycle
	assign dividend  = {1'b1, (qmfg_pkg::RECIP_W - 1)'(nm1 >> 1)};
	assign div_t     = {rem_q, dividend[div_cnt_q]};
	assign div_ge    = div_t >= {1'b0, nm1};
	assign div_rem_n = qmfg_pkg::SITE_W'(div_ge ? div_t - {1'b0, nm1} : div_t);

	assign nx3    = qmfg_pkg::MUL_W'($signed({1'b0, n_eff})) * qmfg_pkg::MUL_W'(x3_q);
	assign triple = mul_rsp.value + (mul_rsp.value <<< 1);

	// saturate to Q20.28
	assign sat_hi    = g_q > qmfg_pkg::GRAD_HI;
	assign sat_lo    = g_q < qmfg_pkg::GRAD_LO;
	assign grad_clip = sat_hi ? qmfg_pkg::GRAD_HI[qmfg_pkg::GRAD_W-1:0]
		: sat_lo ? qmfg_pkg::GRAD_LO[qmfg_pkg::GRAD_W-1:0]
		: g_q[qmfg_pkg::GRAD_W-1:0];

	// operand selection for the shared multiplier
	always_comb begin
		mul_state       = 1'b1;
		mul_req.shift48 = 1'b0;
		mul_req.op_a    = '0;
		mul_req.op_b    = '0;
		unique case (state_q)
			qmfg_pkg::ST_MUL_XX: begin
				mul_req.op_a = qmfg_pkg::MUL_W'(x_q);
				mul_req.op_b = qmfg_pkg::MUL_W'(x_q);
			end
			qmfg_pkg::ST_MUL_X2X: begin
				mul_req.op_a = qmfg_pkg::MUL_W'(x2_q);
				mul_req.op_b = qmfg_pkg::MUL_W'(x_q);
			end
			qmfg_pkg::ST_MUL_S1: begin
				mul_req.op_a = qmfg_pkg::MUL_W'(x2_q);
				mul_req.op_b = qmfg_pkg::MUL_W'(sum1_q);
			end
			qmfg_pkg::ST_MUL_S2: begin
				mul_req.op_a = qmfg_pkg::MUL_W'(x_q);
				mul_req.op_b = qmfg_pkg::MUL_W'(sum2_q);
			end
			qmfg_pkg::ST_MUL_CR: begin
				mul_req.op_a    = c_q;
				mul_req.op_b    = qmfg_pkg::MUL_W'($signed({1'b0, recip_q}));
				mul_req.shift48 = 1'b1;
			end
			default: mul_state = 1'b0;
		endcase
		mul_req.start = mul_state && !issued_q;
	end

	qmfg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= qmfg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qmfg_pkg::ST_IDLE:     if (s_tvalid) state_d = qmfg_pkg::ST_MUL_XX;
			qmfg_pkg::ST_MUL_XX:   if (mul_rsp.done) state_d = qmfg_pkg::ST_MUL_X2X;
			qmfg_pkg::ST_MUL_X2X: begin
				if (mul_rsp.done)
					state_d = emit_q ? qmfg_pkg::ST_COUPLE : qmfg_pkg::ST_LOAD_ACC;
			end
			qmfg_pkg::ST_LOAD_ACC: state_d = load_done ? qmfg_pkg::ST_DIV : qmfg_pkg::ST_IDLE;
			qmfg_pkg::ST_DIV:      if (div_cnt_q == '0) state_d = qmfg_pkg::ST_FETCH;
			qmfg_pkg::ST_FETCH:    state_d = qmfg_pkg::ST_CAPTURE;
			qmfg_pkg::ST_CAPTURE:  state_d = qmfg_pkg::ST_MUL_XX;
			qmfg_pkg::ST_COUPLE:   state_d = qmfg_pkg::ST_MUL_S1;
			qmfg_pkg::ST_MUL_S1:   if (mul_rsp.done) state_d = qmfg_pkg::ST_MUL_S2;
			qmfg_pkg::ST_MUL_S2:   if (mul_rsp.done) state_d = qmfg_pkg::ST_MUL_CR;
			qmfg_pkg::ST_MUL_CR:   if (mul_rsp.done) state_d = qmfg_pkg::ST_SUM;
			qmfg_pkg::ST_SUM:      state_d = qmfg_pkg::ST_PUSH;
			qmfg_pkg::ST_PUSH: begin
				if (out_free)
					state_d = last_site ? qmfg_pkg::ST_IDLE : qmfg_pkg::ST_FETCH;
			end
			default:               state_d = qmfg_pkg::ST_IDLE;
		endcase
	end

	// control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= qmfg_pkg::SITES_RESET;
			load_cnt_q <= '0;
			site_q     <= '0;
			emit_q     <= 1'b0;
			issued_q   <= 1'b0;
			sum1_q     <= '0;
			sum2_q     <= '0;
			sum3_q     <= '0;
			div_cnt_q  <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (mul_req.start)
				issued_q <= 1'b1;
			else if (mul_rsp.done)
				issued_q <= 1'b0;

			if (state_q == qmfg_pkg::ST_PUSH && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			if (cfg_we) begin
				// a new site count drops any part-loaded vector
				cfg_q      <= cfg_wdata;
				load_cnt_q <= '0;
				sum1_q     <= '0;
				sum2_q     <= '0;
				sum3_q     <= '0;
			end else begin
				unique case (state_q)
					qmfg_pkg::ST_IDLE: begin
						if (s_tvalid) begin
							sum1_q <= sum1_q + qmfg_pkg::S1_W'($signed(s_tdata));
							emit_q <= 1'b0;
						end
					end
					qmfg_pkg::ST_LOAD_ACC: begin
						sum2_q     <= sum2_q + qmfg_pkg::S2_W'(x2_q);
						sum3_q     <= sum3_q + qmfg_pkg::S3_W'(x3_q);
						load_cnt_q <= load_cnt_q + 1'b1;
						div_cnt_q  <= qmfg_pkg::DIVC_W'(qmfg_pkg::RECIP_W - 1);
					end
					qmfg_pkg::ST_DIV: begin
						div_cnt_q <= div_cnt_q - 1'b1;
						if (div_cnt_q == '0) begin
							site_q <= '0;
							emit_q <= 1'b1;
						end
					end
					qmfg_pkg::ST_PUSH: begin
						if (out_free) begin
							if (last_site) begin
								load_cnt_q <= '0;
								sum1_q     <= '0;
								sum2_q     <= '0;
								sum3_q     <= '0;
								emit_q     <= 1'b0;
							end else begin
								site_q <= site_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// position store and working values
	always_ff @(posedge clk) begin
		rd_q <= pos_store[site_q];
		unique case (state_q)
			qmfg_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					pos_store[load_cnt_q[qmfg_pkg::SITE_W-1:0]] <= s_tdata;
					x_q <= $signed(s_tdata);
				end
			end
			qmfg_pkg::ST_MUL_XX:   if (mul_rsp.done) x2_q <= qmfg_pkg::X2_W'(mul_rsp.value);
			qmfg_pkg::ST_MUL_X2X:  if (mul_rsp.done) x3_q <= qmfg_pkg::X3_W'(mul_rsp.value);
			qmfg_pkg::ST_LOAD_ACC: rem_q <= '0;
			qmfg_pkg::ST_DIV: begin
				rem_q   <= div_rem_n;
				recip_q <= {recip_q[qmfg_pkg::RECIP_W-2:0], div_ge};
			end
			qmfg_pkg::ST_CAPTURE:  x_q <= $signed(rd_q);
			qmfg_pkg::ST_COUPLE:   c_q <= nx3 - qmfg_pkg::MUL_W'(sum3_q);
			qmfg_pkg::ST_MUL_S1:   if (mul_rsp.done) c_q <= c_q - triple;
			qmfg_pkg::ST_MUL_S2:   if (mul_rsp.done) c_q <= c_q + triple;
			qmfg_pkg::ST_MUL_CR:   if (mul_rsp.done) term_q <= mul_rsp.value;
			qmfg_pkg::ST_SUM: begin
				g_q <= qmfg_pkg::MUL_W'(x_q) + qmfg_pkg::MUL_W'(x3_q) + term_q;
			end
			qmfg_pkg::ST_PUSH: begin
				if (out_free) begin
					m_data_q <= qmfg_pkg::TDATA_W'({qmfg_pkg::IDX_W'(site_q), grad_clip});
					m_last_q <= last_site;
					m_sat_q  <= sat_hi || sat_lo;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_sat_q;

endmodule

[design/qmfg_mul.sv]
// ----------------------------------------------------------------------------
// qmfg_mul: shared rounding multiplier
// Signed product, one 16-bit digit of the second operand per cycle, then a
// round-half-up shift by 28 or 48 bits.
// ----------------------------------------------------------------------------
module qmfg_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qmfg_pkg::qmfg_mul_req_t req,
	output qmfg_pkg::qmfg_mul_rsp_t rsp
);

	logic                                 run_q;
	logic                                 rnd_q;
	logic                                 done_q;
	logic [qmfg_pkg::DIG_W-1:0]           cnt_q;
	logic [qmfg_pkg::MAG_W-1:0]           mag_a_q;
	logic [qmfg_pkg::DIG_N*16-1:0]        mag_b_q;
	logic                                 neg_q;
	logic                                 sh48_q;
	logic [qmfg_pkg::ACC_W-1:0]           acc_q;
	logic [qmfg_pkg::MAG_W-1:0]           rmag_q;

	logic [qmfg_pkg::MAG_W-1:0]           mag_a;
	logic [qmfg_pkg::MAG_W-1:0]           mag_b;
	logic [15:0]                          digit;
	logic [qmfg_pkg::MAG_W+15:0]          pp;
	logic [qmfg_pkg::ACC_W-1:0]           acc_n;
	logic [qmfg_pkg::ACC_W:0]             rsum;

	assign mag_a = qmfg_pkg::MAG_W'(req.op_a[qmfg_pkg::MUL_W-1] ? -req.op_a : req.op_a);
	assign mag_b = qmfg_pkg::MAG_W'(req.op_b[qmfg_pkg::MUL_W-1] ? -req.op_b : req.op_b);
	assign digit = mag_b_q[cnt_q*16 +: 16];
	assign pp    = mag_a_q * digit;
	assign acc_n = qmfg_pkg::ACC_W'({acc_q, 16'b0}) + qmfg_pkg::ACC_W'(pp);
	// negative products round ties towards the higher value: bias the magnitude by one less
	assign rsum  = (qmfg_pkg::ACC_W + 1)'(acc_q)
		+ (sh48_q ? qmfg_pkg::HALF_R : qmfg_pkg::HALF_Q)
		- (qmfg_pkg::ACC_W + 1)'(neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && !run_q && rnd_q;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= qmfg_pkg::DIG_W'(qmfg_pkg::DIG_N - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					rnd_q <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_a_q <= mag_a;
			mag_b_q <= (qmfg_pkg::DIG_N*16)'(mag_b);
			neg_q   <= req.op_a[qmfg_pkg::MUL_W-1] ^ req.op_b[qmfg_pkg::MUL_W-1];
			sh48_q  <= req.shift48;
			acc_q   <= '0;
		end else if (run_q) begin
			acc_q <= acc_n;
		end else if (rnd_q) begin
			rmag_q <= sh48_q ? rsum[qmfg_pkg::FRAC_R +: qmfg_pkg::MAG_W]
				: rsum[qmfg_pkg::FRAC_Q +: qmfg_pkg::MAG_W];
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = neg_q ? -$signed({1'b0, rmag_q}) : $signed({1'b0, rmag_q});

endmodule

[design/qmfg_checker.sv]
// ----------------------------------------------------------------------------
// qmfg_checker: port-level checks for the gradient unit
// Watches the stream ports and flags protocol or result slips.
// ----------------------------------------------------------------------------
module qmfg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [qmfg_pkg::CFG_W-1:0]       cfg_wdata,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [qmfg_pkg::POS_W-1:0]       s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [qmfg_pkg::TDATA_W-1:0]     m_tdata,
	input logic                             m_tlast,
	input logic                             m_tuser
);

	// hold a stalled result unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// a taken position keeps the unit busy for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after a transaction");

	// a flagged result sits on one of the two range limits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:0] == 48'h7FFF_FFFF_FFFF
			|| m_tdata[47:0] == 48'h8000_0000_0000)
		else $error("saturation flag without a clipped value");

	// the padding bits of tdata stay clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:54] == 2'b00)
		else $error("tdata padding not zero");

endmodule

bind quartic_meanfield_gradient_unit qmfg_checker u_qmfg_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quartic_meanfield_gradient_unit
// Streams position vectors under several site counts, predicts every
// gradient in fixed point and compares each output transaction in order.
// ----------------------------------------------------------------------------

// Expected-gradient store and fixed-point predictor of the unit
class gradient_scoreboard;

	typedef struct {
		logic [47:0] gradient;
		logic [5:0]  site_index;
		logic        last_site;
		logic        saturated;
	} gradient_t;

	gradient_t   due_q[$];
	logic [31:0] sites_store[64];
	logic [6:0]  site_count;
	longint      sum_q, sum_q2, sum_q3;
	int          loaded;
	int          errors, checked, clipped, vectors;

	function void clear_vector();
		sum_q = 0;
		sum_q2 = 0;
		sum_q3 = 0;
		loaded = 0;
	endfunction

	function void set_sites(logic [6:0] value);
		site_count = value;
		clear_vector();
	endfunction

	// round(a*b / 2^s), half up, low 64 bits kept
	function longint mul_round(longint a, longint b, int s);
		logic signed [127:0] p;
		p = $signed(128'(a)) * $signed(128'(b));
		p = p + (128'sd1 <<< (s - 1));
		p = p >>> s;
		return longint'(p[63:0]);
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	// Note one accepted position and queue the gradients it completes
	function void note_position(logic [31:0] position);
		int        n;
		longint    q, q2, q3, x, x2, x3, coup, recip, g;
		gradient_t exp_g;
		n = (site_count < 2) ? 2 : ((site_count > 64) ? 64 : int'(site_count));
		q = longint'($signed(position));
		q2 = mul_round(q, q, 28);
		q3 = mul_round(q2, q, 28);
		if (loaded >= n)
			clear_vector();
		sites_store[loaded % 64] = position;
		sum_q += q;
		sum_q2 += q2;
		sum_q3 += q3;
		loaded++;
		if (loaded < n)
			return;
		vectors++;
		recip = ((64'sd1 <<< 48) + (n - 1) / 2) / (n - 1);
		for (int k = 0; k < n; k++) begin
			x = longint'($signed(sites_store[k % 64]));
			x2 = mul_round(x, x, 28);
			x3 = mul_round(x2, x, 28);
			coup = n * x3 - 3 * mul_round(x2, sum_q, 28)
				+ 3 * mul_round(x, sum_q2, 28) - sum_q3;
			g = x + x3 + mul_round(coup, recip, 48);
			exp_g.saturated = 1'b0;
			if (g > (64'sd1 <<< 47) - 1) begin
				g = (64'sd1 <<< 47) - 1;
				exp_g.saturated = 1'b1;
			end
			if (g < -(64'sd1 <<< 47)) begin
				g = -(64'sd1 <<< 47);
				exp_g.saturated = 1'b1;
			end
			exp_g.gradient = g[47:0];
			exp_g.site_index = 6'(k);
			exp_g.last_site = (k + 1 == n);
			due_q.push_back(exp_g);
		end
		clear_vector();
	endfunction

	// Compare one output transaction with the oldest expected gradient
	function void check_gradient(logic [55:0] data, logic last, logic user);
		gradient_t exp_g;
		checked++;
		if (user)
			clipped++;
		if (due_q.size() == 0) begin
			$display("%0t: unexpected gradient %h (last %b, sat %b)", $time, data, last, user);
			errors++;
			return;
		end
		exp_g = due_q.pop_front();
		if (data[47:0] !== exp_g.gradient) begin
			$display("%0t: gradient expected %h actual %h", $time, exp_g.gradient, data[47:0]);
			errors++;
		end
		if (data[53:48] !== exp_g.site_index) begin
			$display("%0t: site_index expected %0d actual %0d", $time, exp_g.site_index,
				data[53:48]);
			errors++;
		end
		if (last !== exp_g.last_site) begin
			$display("%0t: last_site expected %b actual %b", $time, exp_g.last_site, last);
			errors++;
		end
		if (user !== exp_g.saturated) begin
			$display("%0t: saturated expected %b actual %b", $time, exp_g.saturated, user);
			errors++;
		end
	endfunction

endclass

module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	gradient_scoreboard sb;
	int  positions_sent;
	bit  burst_mode;
	bit  hold_output;

	quartic_meanfield_gradient_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one position and withdraw it at the next falling edge once taken
	task send_position(logic [31:0] position);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= position;
		do @(posedge clk); while (!s_tready);
		sb.note_position(position);
		positions_sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task write_sites(logic [6:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_sites(value);
	endtask

	// Wait for every queued gradient, then let any load in flight settle
	task drain();
		while (sb.pending() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function logic [31:0] random_position();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random back-pressure, plus one long hold so the unit fills and stalls
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = burst_mode ? 0 : $urandom_range(0, 12);
			if (hold_output) begin
				gap = 400;
				hold_output = 1'b0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_gradient(m_tdata, m_tlast, m_tuser);
		end
	end

	initial begin
		int          vec_n;
		int          reps;
		logic [6:0]  setting;
		logic [31:0] edge_pos [10];
		sb = new();
		sb.set_sites(7'd64);
		positions_sent = 0;
		burst_mode = 1'b0;
		hold_output = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: site count zero acts as two; extreme position pairs
		edge_pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF};
		write_sites(7'd0);
		foreach (edge_pos[i])
			send_position(edge_pos[i]);
		drain();
		// Site count one also acts as two
		write_sites(7'd1);
		send_position(32'h1000_0000);
		send_position(32'hF000_0000);
		drain();
		// Write mid-vector: discard the partial load
		write_sites(7'd3);
		send_position(32'h7FFF_FFFF);
		send_position(32'h1234_5678);
		drain();
		write_sites(7'd2);
		send_position(32'h2000_0000);
		send_position(32'hE000_0000);
		drain();

		// Oversized count acts as the full 64; hold the output while the next
		// vector is offered so the input stalls behind the waiting gradients
		write_sites(7'd127);
		hold_output = 1'b1;
		for (int i = 0; i < 128; i++)
			send_position(random_position());
		drain();
		write_sites(7'd64);

		// Random phases: mostly short vectors, a few at full length
		while (positions_sent < 360) begin
			case ($urandom_range(0, 9))
				0: setting = 7'($urandom_range(0, 1));
				1: setting = 7'd64;
				2: setting = 7'($urandom_range(65, 127));
				default: setting = 7'($urandom_range(2, 9));
			endcase
			if (setting > 64 && $urandom_range(0, 2) != 0)
				setting = 7'($urandom_range(2, 9));
			write_sites(setting);
			vec_n = (setting < 2) ? 2 : ((setting > 64) ? 64 : int'(setting));
			reps = $urandom_range(1, 3);
			for (int r = 0; r < reps && positions_sent < 360; r++) begin
				burst_mode = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < vec_n; i++)
					send_position(random_position());
			end
			burst_mode = 1'b0;
			drain();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		$display("Covered %0d positions in %0d vectors; %0d gradients checked, %0d clipped.",
			positions_sent, sb.vectors, sb.checked, sb.clipped);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
design/qmfg_pkg.sv
design/qmfg_mul.sv
design/quartic_meanfield_gradient_unit.sv
design/qmfg_checker.sv
sim/tb.sv
